// File: src/contour_direction_segmenter_core_defines.svh
// Assertion macros shared by the checker of the contour direction segmenter.
// Depends on nothing; included by the checker file only.
`ifndef CONTOUR_DIRECTION_SEGMENTER_CORE_DEFINES_SVH
`define CONTOUR_DIRECTION_SEGMENTER_CORE_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define CDSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define CDSC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after a reset edge.
`define CDSC_ASSERT_RST(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cdsc_pkg.sv
// Package of the contour direction segmenter: widths, register indexes,
// shared structs and the direction class table. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cdsc_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W   = 12;
    localparam int CLEN_W    = 16;
    localparam int CLASS_W   = 4;
    localparam int FRAG_W    = 8;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    // Defaults for the top-level parameters.
    localparam int CHUNK_POINTS_DEF = 6;
    localparam int COUNT_BITS_DEF   = 20;

    // Result queue depth (power of two, at least two).
    localparam int OUTQ_DEPTH = 4;

    // Direction table geometry.
    localparam int TABLE_N      = 11;
    localparam int TABLE_OFFSET = 5;
    localparam int TABLE_IDX_W  = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAGMENTS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MERGE_GAP       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MERGE_DIST_SQ   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CONTOUR_PTS = 2'd3;

    // Configuration reset values.
    localparam logic [FRAG_W-1:0] RST_MIN_FRAGMENTS   = 8'd3;
    localparam logic [FRAG_W-1:0] RST_MERGE_GAP       = 8'd3;
    localparam logic [CFG_W-1:0]  RST_MERGE_DIST_SQ   = 24'd324;
    localparam logic [CLEN_W-1:0] RST_MIN_CONTOUR_PTS = 16'd30;

    typedef struct packed {
        logic [FRAG_W-1:0] min_fragments;
        logic [FRAG_W-1:0] merge_gap;
        logic [CFG_W-1:0]  merge_dist_sq;
        logic [CLEN_W-1:0] min_contour_pts;
    } t_cfg;

    // One segment as it leaves the block.
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [CLASS_W-1:0] dir_class;
    } t_seg;

    // Queue entry: a segment and its end-of-run flag.
    typedef struct packed {
        t_seg seg;
        logic last;
    } t_out;

    // What one point means to the run logic after chunking.
    typedef struct packed {
        logic               chunk_done;
        logic [CLASS_W-1:0] dir_class;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic               end_contour;
        logic               end_frame;
    } t_chunk_ev;

    // Up to two segments written to the queue in one cycle, first one first.
    typedef struct packed {
        logic push_a;
        logic push_b;
        t_seg seg_a;
        t_seg seg_b;
    } t_push;

    // Direction class by (start minus end) offsets, each shifted by the table offset.
    localparam logic [CLASS_W-1:0] DIR_TABLE [TABLE_N][TABLE_N] = '{
        '{4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8},
        '{4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8},
        '{4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd1, 4'd1},
        '{4'd5, 4'd5, 4'd5, 4'd5, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd5, 4'd5, 4'd5, 4'd5, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd5, 4'd5, 4'd5, 4'd5, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd5, 4'd5, 4'd4, 4'd4, 4'd3, 4'd3, 4'd3, 4'd2, 4'd2, 4'd1, 4'd1},
        '{4'd4, 4'd4, 4'd4, 4'd4, 4'd3, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2, 4'd2},
        '{4'd4, 4'd4, 4'd4, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2},
        '{4'd4, 4'd4, 4'd4, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2}
    };

    // Table read; indexes past the table give class zero.
    function automatic logic [CLASS_W-1:0] dir_lookup(
        input logic [TABLE_IDX_W-1:0] ix,
        input logic [TABLE_IDX_W-1:0] iy
    );
        logic [CLASS_W-1:0] cls;
        cls = '0;
        if ((ix < TABLE_IDX_W'(TABLE_N)) && (iy < TABLE_IDX_W'(TABLE_N))) begin
            cls = DIR_TABLE[ix][iy];
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

// File: src/cdsc_pt_if.sv
// Point channel of the contour direction segmenter: valid, ready and payload.
// Depends on cdsc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cdsc_pt_if;
    logic                          valid;
    logic                          ready;
    logic [cdsc_pkg::COORD_W-1:0]  point_x;
    logic [cdsc_pkg::COORD_W-1:0]  point_y;
    logic [cdsc_pkg::CLEN_W-1:0]   contour_length;
    logic                          last_of_contour;
    logic                          last_of_frame;

    modport source (
        output valid, point_x, point_y, contour_length, last_of_contour, last_of_frame,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, contour_length, last_of_contour, last_of_frame,
        output ready
    );
endinterface

`default_nettype wire

// File: src/cdsc_seg_if.sv
// Segment channel of the contour direction segmenter: valid, ready and payload.
// Depends on cdsc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cdsc_seg_if;
    logic                          valid;
    logic                          ready;
    logic [cdsc_pkg::COORD_W-1:0]  seg_start_x;
    logic [cdsc_pkg::COORD_W-1:0]  seg_start_y;
    logic [cdsc_pkg::COORD_W-1:0]  seg_end_x;
    logic [cdsc_pkg::COORD_W-1:0]  seg_end_y;
    logic [cdsc_pkg::CLASS_W-1:0]  direction_class;
    logic                          last_of_run;

    modport source (
        output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
               direction_class, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
               direction_class, last_of_run,
        output ready
    );
endinterface

`default_nettype wire

// File: src/contour_direction_segmenter_core.sv
// Pipeline: results of a point pass the input register, the event register
// and the result queue before they show on o_seg. Throughput: one point a
// cycle while the four-entry result queue has room for two more segments.
// Reset: synchronous, active low; clears pipeline valids, run and held state,
// the frame chunk counter and the queue, and loads configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module contour_direction_segmenter_core #(
    parameter int CHUNK_POINTS = cdsc_pkg::CHUNK_POINTS_DEF,
    parameter int COUNT_BITS   = cdsc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [cdsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cdsc_pkg::CFG_W-1:0]      i_cfg_wdata,
    cdsc_pt_if.sink                              i_pt,
    cdsc_seg_if.source                           o_seg
);

    localparam int CW = cdsc_pkg::COORD_W;

    cdsc_pkg::t_cfg             r_cfg;

    // Input register.
    logic                       r_in_valid;
    logic [CW-1:0]              r_in_x;
    logic [CW-1:0]              r_in_y;
    logic [cdsc_pkg::CLEN_W-1:0] r_in_clen;
    logic                       r_in_last_contour;
    logic                       r_in_last_frame;

    // Event register.
    logic                       r_ev_valid;
    cdsc_pkg::t_chunk_ev        r_ev;
    cdsc_pkg::t_chunk_ev        ev;

    cdsc_pkg::t_push            push;
    cdsc_pkg::t_out             head;
    logic                       q_valid;
    logic                       q_room;
    logic                       in_fire;
    logic                       s1_fire;
    logic                       s2_fire;

    // Stage handshakes.
    assign s2_fire    = r_ev_valid && q_room;
    assign s1_fire    = r_in_valid && (!r_ev_valid || s2_fire);
    assign i_pt.ready = !r_in_valid || s1_fire;
    assign in_fire    = i_pt.valid && i_pt.ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_fragments   <= cdsc_pkg::RST_MIN_FRAGMENTS;
            r_cfg.merge_gap       <= cdsc_pkg::RST_MERGE_GAP;
            r_cfg.merge_dist_sq   <= cdsc_pkg::RST_MERGE_DIST_SQ;
            r_cfg.min_contour_pts <= cdsc_pkg::RST_MIN_CONTOUR_PTS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                cdsc_pkg::REG_MIN_FRAGMENTS: begin
                    r_cfg.min_fragments <= i_cfg_wdata[cdsc_pkg::FRAG_W-1:0];
                end
                cdsc_pkg::REG_MERGE_GAP: begin
                    r_cfg.merge_gap <= i_cfg_wdata[cdsc_pkg::FRAG_W-1:0];
                end
                cdsc_pkg::REG_MERGE_DIST_SQ: begin
                    r_cfg.merge_dist_sq <= i_cfg_wdata;
                end
                cdsc_pkg::REG_MIN_CONTOUR_PTS: begin
                    r_cfg.min_contour_pts <= i_cfg_wdata[cdsc_pkg::CLEN_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Input beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (s1_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_x            <= i_pt.point_x;
            r_in_y            <= i_pt.point_y;
            r_in_clen         <= i_pt.contour_length;
            r_in_last_contour <= i_pt.last_of_contour;
            r_in_last_frame   <= i_pt.last_of_frame;
        end
    end

    cdsc_chunker #(
        .CHUNK_POINTS (CHUNK_POINTS)
    ) u_chunker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (s1_fire),
        .i_x            (r_in_x),
        .i_y            (r_in_y),
        .i_clen         (r_in_clen),
        .i_last_contour (r_in_last_contour),
        .i_last_frame   (r_in_last_frame),
        .i_min_pts      (r_cfg.min_contour_pts),
        .o_ev           (ev)
    );

    // Event register between chunking and the run logic.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
        end else if (s1_fire) begin
            r_ev_valid <= 1'b1;
        end else if (s2_fire) begin
            r_ev_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_ev <= ev;
        end
    end

    cdsc_run_merge #(
        .COUNT_BITS (COUNT_BITS)
    ) u_run_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s2_fire),
        .i_ev    (r_ev),
        .i_cfg   (r_cfg),
        .o_push  (push)
    );

    cdsc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_seg.ready),
        .o_head  (head),
        .o_valid (q_valid),
        .o_room  (q_room)
    );

    // Output beat.
    assign o_seg.valid           = q_valid;
    assign o_seg.seg_start_x     = head.seg.start_x;
    assign o_seg.seg_start_y     = head.seg.start_y;
    assign o_seg.seg_end_x       = head.seg.end_x;
    assign o_seg.seg_end_y       = head.seg.end_y;
    assign o_seg.direction_class = head.seg.dir_class;
    assign o_seg.last_of_run     = head.last;

endmodule

`default_nettype wire

// File: src/cdsc_chunker.sv
// Chunker: counts points into chunks and classifies each finished chunk
// by its start-to-end offset. Depends on cdsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdsc_chunker #(
    parameter int CHUNK_POINTS = cdsc_pkg::CHUNK_POINTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire logic [cdsc_pkg::COORD_W-1:0]  i_x,
    input  wire logic [cdsc_pkg::COORD_W-1:0]  i_y,
    input  wire logic [cdsc_pkg::CLEN_W-1:0]   i_clen,
    input  wire logic                          i_last_contour,
    input  wire logic                          i_last_frame,
    input  wire logic [cdsc_pkg::CLEN_W-1:0]   i_min_pts,
    output cdsc_pkg::t_chunk_ev                o_ev
);

    localparam int PH_W  = $clog2(CHUNK_POINTS);
    localparam int OFS_W = cdsc_pkg::COORD_W + 2;
    localparam logic [PH_W-1:0] LAST_PHASE = PH_W'(CHUNK_POINTS - 1);

    logic [PH_W-1:0]               r_phase;
    logic [PH_W-1:0]               n_phase;
    logic [cdsc_pkg::COORD_W-1:0]  r_start_x;
    logic [cdsc_pkg::COORD_W-1:0]  r_start_y;

    logic                          take;
    logic                          at_end;
    logic                          end_contour;
    logic signed [OFS_W-1:0]       ofs_x;
    logic signed [OFS_W-1:0]       ofs_y;
    logic                          in_range;
    logic [cdsc_pkg::CLASS_W-1:0]  cls;

    // A point counts only if its contour is long enough.
    assign take        = (i_clen >= i_min_pts);
    assign at_end      = (r_phase >= LAST_PHASE);
    assign end_contour = i_last_contour | i_last_frame;

    // Offsets start minus end, shifted so that the table starts at zero.
    always_comb begin
        ofs_x = $signed({2'b00, r_start_x}) - $signed({2'b00, i_x})
              + OFS_W'(cdsc_pkg::TABLE_OFFSET);
        ofs_y = $signed({2'b00, r_start_y}) - $signed({2'b00, i_y})
              + OFS_W'(cdsc_pkg::TABLE_OFFSET);
        in_range = (ofs_x >= 0) && (ofs_x < OFS_W'(cdsc_pkg::TABLE_N))
                && (ofs_y >= 0) && (ofs_y < OFS_W'(cdsc_pkg::TABLE_N));
        cls = '0;
        if (in_range) begin
            cls = cdsc_pkg::dir_lookup(ofs_x[cdsc_pkg::TABLE_IDX_W-1:0],
                                       ofs_y[cdsc_pkg::TABLE_IDX_W-1:0]);
        end
    end

    // Chunk position for the next point.
    always_comb begin
        n_phase = r_phase;
        if (take) begin
            n_phase = at_end ? '0 : r_phase + PH_W'(1);
        end
        if (end_contour) begin
            n_phase = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
        end
    end

    // The first point of a chunk is its start.
    always_ff @(posedge i_clk) begin
        if (i_fire && take && (r_phase == '0)) begin
            r_start_x <= i_x;
            r_start_y <= i_y;
        end
    end

    // Event for the run logic.
    always_comb begin
        o_ev.chunk_done  = take && at_end;
        o_ev.dir_class   = cls;
        o_ev.start_x     = r_start_x;
        o_ev.start_y     = r_start_y;
        o_ev.end_x       = i_x;
        o_ev.end_y       = i_y;
        o_ev.end_contour = end_contour;
        o_ev.end_frame   = i_last_frame;
    end

endmodule

`default_nettype wire

// File: src/cdsc_run_merge.sv
// Run and merge logic: builds runs of equal-class chunks, keeps long ones,
// merges them into the held segment and flushes at frame end. Depends on cdsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdsc_run_merge #(
    parameter int COUNT_BITS = cdsc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  cdsc_pkg::t_chunk_ev       i_ev,
    input  cdsc_pkg::t_cfg            i_cfg,
    output cdsc_pkg::t_push           o_push
);

    localparam int CW    = cdsc_pkg::COORD_W;
    localparam int KW    = cdsc_pkg::CLASS_W;
    localparam int FW    = cdsc_pkg::FRAG_W;
    localparam int SQ_W  = 2 * (CW + 1);
    localparam int DSQ_W = SQ_W + 1;
    localparam logic [FW-1:0] FRAG_MAX = {FW{1'b1}};

    // Frame chunk counter.
    logic [COUNT_BITS-1:0] r_frag_count;
    logic [COUNT_BITS-1:0] n_frag_count;
    logic [COUNT_BITS-1:0] frag_inc;

    // Open run.
    logic                  r_run_open;
    logic [KW-1:0]         r_run_class;
    logic [FW-1:0]         r_run_frags;
    logic [CW-1:0]         r_run_sx, r_run_sy, r_run_ex, r_run_ey;
    logic [COUNT_BITS-1:0] r_run_sidx, r_run_eidx;

    // Held segment.
    logic                  r_held_valid;
    logic [KW-1:0]         r_held_class;
    logic [CW-1:0]         r_held_sx, r_held_sy, r_held_ex, r_held_ey;
    logic [COUNT_BITS-1:0] r_held_eidx;

    // Run after this chunk.
    logic                  m_open;
    logic [KW-1:0]         m_class;
    logic [FW-1:0]         m_frags;
    logic [CW-1:0]         m_sx, m_sy, m_ex, m_ey;
    logic [COUNT_BITS-1:0] m_sidx, m_eidx;
    logic                  close_chunk;
    logic                  close_end;
    logic                  kept;

    // Merge test.
    logic signed [SQ_W-1:0] ddx, ddy;
    logic [SQ_W-1:0]        sqx, sqy;
    logic [DSQ_W-1:0]       dsq;
    logic [COUNT_BITS-1:0]  gap;
    logic                   merge;

    // Held segment after the offer.
    logic                  h_valid;
    logic [KW-1:0]         h_class;
    logic [CW-1:0]         h_sx, h_sy, h_ex, h_ey;
    logic [COUNT_BITS-1:0] h_eidx;

    assign frag_inc = r_frag_count + COUNT_BITS'(1);

    // Chunk step: open, extend or close the run.
    always_comb begin
        m_open      = r_run_open;
        m_class     = r_run_class;
        m_frags     = r_run_frags;
        m_sx        = r_run_sx;
        m_sy        = r_run_sy;
        m_ex        = r_run_ex;
        m_ey        = r_run_ey;
        m_sidx      = r_run_sidx;
        m_eidx      = r_run_eidx;
        close_chunk = 1'b0;
        if (i_ev.chunk_done) begin
            if (!r_run_open) begin
                if (i_ev.dir_class != '0) begin
                    m_open  = 1'b1;
                    m_class = i_ev.dir_class;
                    m_frags = FW'(1);
                    m_sx    = i_ev.start_x;
                    m_sy    = i_ev.start_y;
                    m_ex    = i_ev.end_x;
                    m_ey    = i_ev.end_y;
                    m_sidx  = frag_inc;
                    m_eidx  = frag_inc;
                end
            end else if (i_ev.dir_class == r_run_class) begin
                m_ex   = i_ev.end_x;
                m_ey   = i_ev.end_y;
                m_eidx = frag_inc;
                if (r_run_frags != FRAG_MAX) begin
                    m_frags = r_run_frags + FW'(1);
                end
            end else begin
                close_chunk = 1'b1;
                m_open      = 1'b0;
            end
        end
        close_end = i_ev.end_contour && m_open;
        kept      = (close_chunk || close_end) && (m_frags >= i_cfg.min_fragments);
    end

    // Squared distance from the held end to the run start, and the index gap.
    always_comb begin
        ddx   = SQ_W'($signed({1'b0, m_sx}) - $signed({1'b0, r_held_ex}));
        ddy   = SQ_W'($signed({1'b0, m_sy}) - $signed({1'b0, r_held_ey}));
        sqx   = ddx * ddx;
        sqy   = ddy * ddy;
        dsq   = {1'b0, sqx} + {1'b0, sqy};
        gap   = m_sidx - r_held_eidx;
        merge = r_held_valid && (r_held_class == m_class)
             && (gap <= COUNT_BITS'(i_cfg.merge_gap))
             && (dsq <= DSQ_W'(i_cfg.merge_dist_sq));
    end

    // Offer a kept run to the held segment.
    always_comb begin
        h_valid = r_held_valid;
        h_class = r_held_class;
        h_sx    = r_held_sx;
        h_sy    = r_held_sy;
        h_ex    = r_held_ex;
        h_ey    = r_held_ey;
        h_eidx  = r_held_eidx;
        if (kept) begin
            if (merge) begin
                h_ex   = m_ex;
                h_ey   = m_ey;
                h_eidx = m_eidx;
            end else begin
                h_valid = 1'b1;
                h_class = m_class;
                h_sx    = m_sx;
                h_sy    = m_sy;
                h_ex    = m_ex;
                h_ey    = m_ey;
                h_eidx  = m_eidx;
            end
        end
    end

    // Results: the displaced held segment, then the frame-end flush.
    always_comb begin
        o_push.push_a            = i_fire && kept && !merge && r_held_valid;
        o_push.seg_a.start_x     = r_held_sx;
        o_push.seg_a.start_y     = r_held_sy;
        o_push.seg_a.end_x       = r_held_ex;
        o_push.seg_a.end_y       = r_held_ey;
        o_push.seg_a.dir_class   = r_held_class;
        o_push.push_b            = i_fire && i_ev.end_frame && h_valid;
        o_push.seg_b.start_x     = h_sx;
        o_push.seg_b.start_y     = h_sy;
        o_push.seg_b.end_x       = h_ex;
        o_push.seg_b.end_y       = h_ey;
        o_push.seg_b.dir_class   = h_class;
    end

    always_comb begin
        n_frag_count = r_frag_count;
        if (i_ev.chunk_done) begin
            n_frag_count = frag_inc;
        end
        if (i_ev.end_frame) begin
            n_frag_count = '0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frag_count <= '0;
            r_run_open   <= 1'b0;
            r_held_valid <= 1'b0;
        end else if (i_fire) begin
            r_frag_count <= n_frag_count;
            r_run_open   <= m_open && !close_end;
            r_held_valid <= h_valid && !i_ev.end_frame;
        end
    end

    // Run and held payload.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_run_class  <= m_class;
            r_run_frags  <= m_frags;
            r_run_sx     <= m_sx;
            r_run_sy     <= m_sy;
            r_run_ex     <= m_ex;
            r_run_ey     <= m_ey;
            r_run_sidx   <= m_sidx;
            r_run_eidx   <= m_eidx;
            r_held_class <= h_class;
            r_held_sx    <= h_sx;
            r_held_sy    <= h_sy;
            r_held_ex    <= h_ex;
            r_held_ey    <= h_ey;
            r_held_eidx  <= h_eidx;
        end
    end

endmodule

`default_nettype wire

// File: src/cdsc_outq.sv
// Result queue: takes up to two segments a cycle, hands out one a cycle while popped.
// Depends on cdsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdsc_outq (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  cdsc_pkg::t_push i_push,
    input  wire logic       i_pop,
    output cdsc_pkg::t_out  o_head,
    output logic            o_valid,
    output logic            o_room
);

    localparam int DEPTH = cdsc_pkg::OUTQ_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cdsc_pkg::t_out r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0]       n_push;
    logic [PTR_W-1:0] wr_b;
    logic             pop_ok;

    assign n_push  = {1'b0, i_push.push_a} + {1'b0, i_push.push_b};
    assign wr_b    = i_push.push_a ? r_wr + PTR_W'(1) : r_wr;
    assign o_valid = (r_cnt != '0);
    assign pop_ok  = i_pop && o_valid;
    // Room for two beats, counted from the registered fill level.
    assign o_room  = (r_cnt <= CNT_W'(DEPTH - 2));
    assign o_head  = r_mem[r_rd];

    // Entry writes; the first segment is last only when no second follows.
    always_ff @(posedge i_clk) begin
        if (i_push.push_a) begin
            r_mem[r_wr].seg  <= i_push.seg_a;
            r_mem[r_wr].last <= !i_push.push_b;
        end
        if (i_push.push_b) begin
            r_mem[wr_b].seg  <= i_push.seg_b;
            r_mem[wr_b].last <= 1'b1;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PTR_W'(n_push);
            r_rd  <= r_rd + PTR_W'(pop_ok);
            r_cnt <= r_cnt + CNT_W'(n_push) - CNT_W'(pop_ok);
        end
    end

endmodule

`default_nettype wire

// File: src/cdsc_checker.sv
// Port checker of the contour direction segmenter, bound to the top level.
// Depends on cdsc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "contour_direction_segmenter_core_defines.svh"

module cdsc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [cdsc_pkg::COORD_W-1:0]  i_out_start_x,
    input wire logic [cdsc_pkg::COORD_W-1:0]  i_out_start_y,
    input wire logic [cdsc_pkg::COORD_W-1:0]  i_out_end_x,
    input wire logic [cdsc_pkg::COORD_W-1:0]  i_out_end_y,
    input wire logic [cdsc_pkg::CLASS_W-1:0]  i_out_class,
    input wire logic                          i_out_last
);

    // No result is pending right after a reset edge.
    `CDSC_ASSERT_RST(a_rst_empty, i_clk, i_rst_n, !i_out_valid, "result valid after reset")

    // With nothing waiting at the output, an offered point is taken at once.
    `CDSC_ASSERT_IMP(a_idle_ready, i_clk, i_rst_n, !i_out_valid && i_in_valid, i_in_ready, "input stalled with empty output")

    // Emitted segments always carry a nonzero table class.
    `CDSC_ASSERT_IMP(a_class_range, i_clk, i_rst_n, i_out_valid, (i_out_class != 4'd0) && (i_out_class <= 4'd8), "segment class out of range")

    // The second segment of a point is ready as soon as the first is taken.
    `CDSC_ASSERT_NXT(a_run_follow, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_last, i_out_valid, "missing second segment of a point")

    // A stalled segment beat keeps its payload.
    `CDSC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_start_x) && $stable(i_out_start_y) && $stable(i_out_end_x) && $stable(i_out_end_y) && $stable(i_out_class) && $stable(i_out_last), "stalled segment changed")

endmodule

bind contour_direction_segmenter_core cdsc_checker u_cdsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pt.valid),
    .i_in_ready    (i_pt.ready),
    .i_out_valid   (o_seg.valid),
    .i_out_ready   (o_seg.ready),
    .i_out_start_x (o_seg.seg_start_x),
    .i_out_start_y (o_seg.seg_start_y),
    .i_out_end_x   (o_seg.seg_end_x),
    .i_out_end_y   (o_seg.seg_end_y),
    .i_out_class   (o_seg.direction_class),
    .i_out_last    (o_seg.last_of_run)
);

`default_nettype wire

// File: tb/cdsc_segment_checker.sv
// Segment checker for the contour direction segmenter: watches the point, segment and
// register ports, predicts the segments of each point beat and compares them in order.
// Depends on cdsc_pkg and on the cdsc_pt_if and cdsc_seg_if interfaces.
`timescale 1ns / 1ps

module cdsc_segment_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [cdsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cdsc_pkg::CFG_W-1:0]      i_cfg_wdata,
    cdsc_pt_if                                   i_pt,
    cdsc_seg_if                                  i_seg,
    output int                                   o_mismatches,
    output int                                   o_pending
);

    localparam int CHUNK_LEN   = 6;
    localparam int SHIFT       = 5;
    localparam int PRINT_LIMIT = 100;

    // Direction class indexed by (start minus end) offsets, each shifted by SHIFT.
    localparam bit [3:0] CLASS_OF_OFFSET [0:10][0:10] = '{
        '{6, 6, 6, 7, 7, 7, 7, 7, 8, 8, 8},
        '{6, 6, 6, 7, 7, 7, 7, 7, 8, 8, 8},
        '{6, 6, 6, 6, 7, 7, 7, 8, 8, 8, 8},
        '{5, 5, 6, 6, 7, 7, 7, 8, 8, 1, 1},
        '{5, 5, 5, 5, 0, 0, 0, 1, 1, 1, 1},
        '{5, 5, 5, 5, 0, 0, 0, 1, 1, 1, 1},
        '{5, 5, 5, 5, 0, 0, 0, 1, 1, 1, 1},
        '{5, 5, 4, 4, 3, 3, 3, 2, 2, 1, 1},
        '{4, 4, 4, 4, 3, 3, 3, 2, 2, 2, 2},
        '{4, 4, 4, 3, 3, 3, 3, 3, 2, 2, 2},
        '{4, 4, 4, 3, 3, 3, 3, 3, 2, 2, 2}
    };

    // Register copies.
    logic [7:0]  min_chunk_reg;
    logic [7:0]  merge_gap_reg;
    logic [23:0] merge_dist_reg;
    logic [15:0] min_points_reg;

    // Chunking state.
    logic [2:0]  phase;
    logic [11:0] chunk_x, chunk_y;
    logic [19:0] chunk_index;

    // Open run.
    logic        run_open;
    logic [3:0]  run_cls;
    logic [7:0]  run_frags;
    logic [11:0] run_sx, run_sy, run_ex, run_ey;
    logic [19:0] run_sidx, run_eidx;

    // Held segment waiting for a possible merge.
    logic        held_valid;
    logic [11:0] held_sx, held_sy, held_ex, held_ey;
    logic [3:0]  held_cls;
    logic [19:0] held_eidx;

    int segments_seen;

    cdsc_pkg::t_out segments_due[$];
    cdsc_pkg::t_out point_segments[$];

    initial begin
        o_mismatches  = 0;
        o_pending     = 0;
        segments_seen = 0;
    end

    task automatic report_mismatch(input string what);
        if (o_mismatches < PRINT_LIMIT) begin
            $display("%0t: %s", $time, what);
        end
        o_mismatches++;
    endtask

    task automatic reset_prediction();
        min_chunk_reg  = cdsc_pkg::RST_MIN_FRAGMENTS;
        merge_gap_reg  = cdsc_pkg::RST_MERGE_GAP;
        merge_dist_reg = cdsc_pkg::RST_MERGE_DIST_SQ;
        min_points_reg = cdsc_pkg::RST_MIN_CONTOUR_PTS;
        phase       = '0;
        chunk_x     = '0;
        chunk_y     = '0;
        chunk_index = '0;
        run_open  = 1'b0;
        run_cls   = '0;
        run_frags = '0;
        run_sx = '0; run_sy = '0; run_ex = '0; run_ey = '0;
        run_sidx = '0; run_eidx = '0;
        held_valid = 1'b0;
        held_sx = '0; held_sy = '0; held_ex = '0; held_ey = '0;
        held_cls = '0; held_eidx = '0;
        segments_due.delete();
    endtask

    task automatic write_register(input logic [cdsc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [cdsc_pkg::CFG_W-1:0] val);
        case (idx)
            cdsc_pkg::REG_MIN_FRAGMENTS:   min_chunk_reg  = val[7:0];
            cdsc_pkg::REG_MERGE_GAP:       merge_gap_reg  = val[7:0];
            cdsc_pkg::REG_MERGE_DIST_SQ:   merge_dist_reg = val[23:0];
            cdsc_pkg::REG_MIN_CONTOUR_PTS: min_points_reg = val[15:0];
            default: ;
        endcase
    endtask

    function automatic int coord_diff(input logic [11:0] a, input logic [11:0] b);
        return int'({20'd0, a}) - int'({20'd0, b});
    endfunction

    // Offsets outside the table give class zero.
    function automatic logic [3:0] chunk_class(input logic [11:0] ex, input logic [11:0] ey);
        int dx;
        int dy;
        dx = coord_diff(chunk_x, ex);
        dy = coord_diff(chunk_y, ey);
        if (dx < -SHIFT || dx > SHIFT || dy < -SHIFT || dy > SHIFT) begin
            return 4'd0;
        end
        return CLASS_OF_OFFSET[dx + SHIFT][dy + SHIFT];
    endfunction

    task automatic emit_held();
        cdsc_pkg::t_out r;
        r.seg.start_x   = held_sx;
        r.seg.start_y   = held_sy;
        r.seg.end_x     = held_ex;
        r.seg.end_y     = held_ey;
        r.seg.dir_class = held_cls;
        r.last          = 1'b0;
        point_segments.insert(point_segments.size(), r);
    endtask

    // A kept run either extends the held segment or pushes it out.
    task automatic offer_run();
        logic [19:0] gap;
        longint      dx;
        longint      dy;
        if (held_valid && held_cls == run_cls) begin
            gap = run_sidx - held_eidx;
            dx  = coord_diff(run_sx, held_ex);
            dy  = coord_diff(run_sy, held_ey);
            if (gap <= merge_gap_reg && dx * dx + dy * dy <= longint'({40'd0, merge_dist_reg}))
            begin
                held_ex   = run_ex;
                held_ey   = run_ey;
                held_eidx = run_eidx;
                return;
            end
        end
        if (held_valid) begin
            emit_held();
        end
        held_valid = 1'b1;
        held_sx   = run_sx;
        held_sy   = run_sy;
        held_ex   = run_ex;
        held_ey   = run_ey;
        held_cls  = run_cls;
        held_eidx = run_eidx;
    endtask

    task automatic close_run();
        if (run_open && run_frags >= min_chunk_reg) begin
            offer_run();
        end
        run_open = 1'b0;
    endtask

    // Works out the segments that one point beat causes and queues them.
    task automatic predict_point(input logic [11:0] x, input logic [11:0] y,
                                 input logic [15:0] clen, input logic contour_end,
                                 input logic frame_end);
        logic [3:0] cls;
        point_segments.delete();
        if (clen >= min_points_reg) begin
            if (phase == 3'd0) begin
                chunk_x = x;
                chunk_y = y;
            end
            if (phase >= CHUNK_LEN - 1) begin
                cls         = chunk_class(x, y);
                phase       = '0;
                chunk_index = chunk_index + 20'd1;
                if (!run_open) begin
                    if (cls != 4'd0) begin
                        run_open  = 1'b1;
                        run_cls   = cls;
                        run_frags = 8'd1;
                        run_sx = chunk_x; run_sy = chunk_y;
                        run_ex = x;       run_ey = y;
                        run_sidx = chunk_index;
                        run_eidx = chunk_index;
                    end
                end else if (cls == run_cls) begin
                    run_ex   = x;
                    run_ey   = y;
                    run_eidx = chunk_index;
                    if (run_frags != 8'hFF) begin
                        run_frags = run_frags + 8'd1;
                    end
                end else begin
                    // A class change ends the run and drops this chunk.
                    close_run();
                end
            end else begin
                phase = phase + 3'd1;
            end
        end
        if (contour_end || frame_end) begin
            close_run();
            phase = '0;
        end
        if (frame_end) begin
            if (held_valid) begin
                emit_held();
            end
            held_valid  = 1'b0;
            chunk_index = '0;
        end
        foreach (point_segments[i]) begin
            point_segments[i].last = (i == point_segments.size() - 1);
            segments_due.insert(segments_due.size(), point_segments[i]);
        end
    endtask

    task automatic check_segment();
        cdsc_pkg::t_out want;
        string          bad;
        bad = "";
        if (segments_due.size() == 0) begin
            report_mismatch($sformatf("segment %0d arrived with none predicted", segments_seen));
        end else begin
            want = segments_due.pop_front();
            if (i_seg.seg_start_x !== want.seg.start_x) begin
                bad = {bad, $sformatf(" start_x %0d/%0d", i_seg.seg_start_x, want.seg.start_x)};
            end
            if (i_seg.seg_start_y !== want.seg.start_y) begin
                bad = {bad, $sformatf(" start_y %0d/%0d", i_seg.seg_start_y, want.seg.start_y)};
            end
            if (i_seg.seg_end_x !== want.seg.end_x) begin
                bad = {bad, $sformatf(" end_x %0d/%0d", i_seg.seg_end_x, want.seg.end_x)};
            end
            if (i_seg.seg_end_y !== want.seg.end_y) begin
                bad = {bad, $sformatf(" end_y %0d/%0d", i_seg.seg_end_y, want.seg.end_y)};
            end
            if (i_seg.direction_class !== want.seg.dir_class) begin
                bad = {bad, $sformatf(" class %0d/%0d", i_seg.direction_class,
                                      want.seg.dir_class)};
            end
            if (i_seg.last_of_run !== want.last) begin
                bad = {bad, $sformatf(" last %0b/%0b", i_seg.last_of_run, want.last)};
            end
            if (bad != "") begin
                report_mismatch($sformatf("segment %0d got/expected:%s", segments_seen, bad));
            end
        end
        segments_seen++;
    endtask

    // Every beat is sampled at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_prediction();
        end else begin
            if (i_cfg_wr_en) begin
                write_register(i_cfg_index, i_cfg_wdata);
            end
            if (i_pt.valid && i_pt.ready) begin
                predict_point(i_pt.point_x, i_pt.point_y, i_pt.contour_length,
                              i_pt.last_of_contour, i_pt.last_of_frame);
            end
            if (i_seg.valid && i_seg.ready) begin
                check_segment();
            end
        end
        o_pending = segments_due.size();
    end

endmodule

// File: tb/tb_top.sv
// Top of the contour direction segmenter testbench: clock, reset, register writes,
// contour point traffic with idle gaps, output stalls and the final verdict.
// Depends on cdsc_pkg, both channel interfaces, the core and cdsc_segment_checker.
`timescale 1ns / 1ps

module tb_top;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSED} t_rx_mode;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_wr_en;
    logic [cdsc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cdsc_pkg::CFG_W-1:0]     cfg_wdata;
    int                             mismatches;
    int                             pending;

    cdsc_pt_if  pt_bus();
    cdsc_seg_if seg_bus();

    contour_direction_segmenter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_pt        (pt_bus),
        .o_seg       (seg_bus)
    );

    cdsc_segment_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_pt            (pt_bus),
        .i_seg           (seg_bus),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    always #2 i_clk = ~i_clk;

    // Output stalls: modes of random length, from always ready to a slow pulse.
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 120);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   seg_bus.ready <= 1'b1;
            RX_COIN:   seg_bus.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: seg_bus.ready <= ($urandom_range(0, 3) == 0);
            default:   seg_bus.ready <= (rx_tick % 8 == 0);
        endcase
    end

    // Sender state.
    int          burst_left  = 0;
    int          points_sent = 0;
    logic [15:0] clen_floor  = cdsc_pkg::RST_MIN_CONTOUR_PTS;

    // One point beat; starts and ends at a falling edge, idles between bursts.
    task automatic send_point(input logic [11:0] x, input logic [11:0] y,
                              input logic [15:0] clen, input logic loc, input logic lof);
        int idle;
        if (burst_left <= 0) begin
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (idle > 0) begin
                pt_bus.valid <= 1'b0;
                repeat (idle) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
        end
        pt_bus.valid           <= 1'b1;
        pt_bus.point_x         <= x;
        pt_bus.point_y         <= y;
        pt_bus.contour_length  <= clen;
        pt_bus.last_of_contour <= loc;
        pt_bus.last_of_frame   <= lof;
        @(posedge i_clk);
        while (!pt_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        points_sent++;
    endtask

    // Stop sending and wait until every predicted segment has come out.
    task automatic drain_results();
        pt_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // Registers change only with the block idle; the extra cycles cover points
    // still in the pipeline that cause no segment.
    task automatic load_setting(input logic [7:0] min_chunks, input logic [7:0] gap,
                                input logic [23:0] dist_sq, input logic [15:0] min_pts);
        drain_results();
        repeat (8) @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= cdsc_pkg::REG_MIN_FRAGMENTS;
        cfg_wdata <= cdsc_pkg::CFG_W'(min_chunks);
        @(negedge i_clk);
        cfg_index <= cdsc_pkg::REG_MERGE_GAP;
        cfg_wdata <= cdsc_pkg::CFG_W'(gap);
        @(negedge i_clk);
        cfg_index <= cdsc_pkg::REG_MERGE_DIST_SQ;
        cfg_wdata <= dist_sq;
        @(negedge i_clk);
        cfg_index <= cdsc_pkg::REG_MIN_CONTOUR_PTS;
        cfg_wdata <= cdsc_pkg::CFG_W'(min_pts);
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        clen_floor = min_pts;
    endtask

    // Six points on a straight line, which make one full chunk.
    task automatic send_chunk(input logic [11:0] x0, input logic [11:0] y0,
                              input int sx, input int sy);
        int k;
        for (k = 0; k < 6; k++) begin
            send_point(x0 + 12'(k * sx), y0 + 12'(k * sy), 16'hFFFF, 1'b0, 1'b0);
        end
    endtask

    // Contour length field: mostly at or above the skip threshold, sometimes
    // right at its edge or fully random.
    function automatic logic [15:0] length_field(input int npts);
        int m;
        int v;
        m = $urandom_range(0, 19);
        if (m == 0) begin
            return 16'($urandom_range(0, 65535));
        end
        if (m == 1) begin
            return (clen_floor == 16'd0) ? 16'd0 : clen_floor - 16'd1;
        end
        if (m == 2) begin
            return clen_floor;
        end
        v = (npts >= clen_floor) ? npts : int'(clen_floor) + int'($urandom_range(0, 3));
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    // A traced contour: a walk with a steady heading, short wobbles that
    // break and restart runs, rare heading changes, doubled steps and jumps.
    task automatic send_contour(input int npts, input bit frame_end);
        logic [11:0] x;
        logic [11:0] y;
        logic [15:0] clen;
        logic        loc;
        logic        lof;
        int          hx, hy, sx, sy, r, k;
        x    = 12'($urandom_range(0, 4095));
        y    = 12'($urandom_range(0, 4095));
        hx   = int'($urandom_range(0, 2)) - 1;
        hy   = int'($urandom_range(0, 2)) - 1;
        clen = length_field(npts);
        for (k = 0; k < npts; k++) begin
            if (k == npts - 1) begin
                loc = !frame_end || ($urandom_range(0, 1) == 1);
            end else begin
                loc = ($urandom_range(0, 199) == 0);
            end
            lof = frame_end && (k == npts - 1);
            send_point(x, y, clen, loc, lof);
            r  = $urandom_range(0, 99);
            sx = hx;
            sy = hy;
            if (r < 3) begin
                hx = int'($urandom_range(0, 2)) - 1;
                hy = int'($urandom_range(0, 2)) - 1;
            end else if (r < 8) begin
                sx = int'($urandom_range(0, 2)) - 1;
                sy = int'($urandom_range(0, 2)) - 1;
            end else if (r < 10) begin
                sx = 2 * hx + 1;
                sy = 2 * hy;
            end else if (r == 10) begin
                x = 12'($urandom_range(0, 4095));
                y = 12'($urandom_range(0, 4095));
            end
            x = x + 12'(sx);
            y = y + 12'(sy);
        end
    endtask

    // Random frames until the quota is met; pauses now and then until all
    // results are out.
    task automatic run_random(input int quota);
        int first;
        int frames;
        int n, c, m, npts;
        first  = points_sent;
        frames = 0;
        while (points_sent - first < quota) begin
            n = $urandom_range(1, 4);
            for (c = 0; c < n; c++) begin
                m = $urandom_range(0, 9);
                if (m == 0) begin
                    npts = $urandom_range(1, 5);
                end else if (m == 1) begin
                    npts = $urandom_range(60, 120);
                end else begin
                    npts = $urandom_range(6, 48);
                end
                send_contour(npts, c == n - 1);
            end
            frames++;
            if (frames % 7 == 3) begin
                drain_results();
            end
        end
    endtask

    initial begin
        i_rst_n                = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_index              = cdsc_pkg::REG_MIN_FRAGMENTS;
        cfg_wdata              = '0;
        pt_bus.valid           = 1'b0;
        pt_bus.point_x         = '0;
        pt_bus.point_y         = '0;
        pt_bus.contour_length  = '0;
        pt_bus.last_of_contour = 1'b0;
        pt_bus.last_of_frame   = 1'b0;
        seg_bus.ready          = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: single-chunk segments, tight merge limits, short skip threshold.
        load_setting(8'd1, 8'd1, 24'd2, 16'd6);
        // Points of a skipped contour; the contour mark still acts.
        send_point(12'd7, 12'd4095, 16'd0, 1'b0, 1'b0);
        send_point(12'd4095, 12'd0, 16'd5, 1'b1, 1'b0);
        // A class-2 chunk at the top corner opens a run.
        send_chunk(12'd4095, 12'd4095, -1, -1);
        // A class-7 chunk closes it; the run becomes the held segment.
        send_chunk(12'd0, 12'd0, 1, 0);
        // Offsets beyond the table give class zero and no run.
        send_chunk(12'd2000, 12'd9, 2, 1);
        // Trailing points of a partial chunk, then a frame end that flushes.
        send_point(12'd1, 12'd2, 16'hFFFF, 1'b0, 1'b0);
        send_point(12'd3, 12'd4, 16'hFFFF, 1'b0, 1'b1);

        // Random phases across low, high and typical register settings.
        load_setting(8'd1, 8'd0, 24'd0, 16'd0);
        run_random(300);
        load_setting(8'd255, 8'd255, 24'hFFFFFF, 16'hFFFF);
        run_random(150);
        load_setting(8'd2, 8'd5, 24'd50, 16'd10);
        run_random(350);
        load_setting(8'd1, 8'd255, 24'hFFFFFF, 16'd6);
        run_random(300);
        load_setting(cdsc_pkg::RST_MIN_FRAGMENTS, cdsc_pkg::RST_MERGE_GAP,
                     cdsc_pkg::RST_MERGE_DIST_SQ, cdsc_pkg::RST_MIN_CONTOUR_PTS);
        run_random(600);

        drain_results();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("contour_direction_segmenter_core: match");
        end else begin
            $display("contour_direction_segmenter_core: mismatch");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #(3_000_000);
        $display("contour_direction_segmenter_core: mismatch");
        $finish;
    end

endmodule
